// ===== src/crcfpe_pkg.sv =====
// crcfpe_pkg: constants, sequence positions and crc step functions for the
// framed packet encoder; no dependencies
package crcfpe_pkg;

  localparam logic [7:0]  SYNC_BYTE    = 8'h55;
  localparam logic [7:0]  CRC8_INIT    = 8'h77;
  localparam logic [7:0]  CRC8_POLY    = 8'h8C;
  localparam logic [15:0] CRC16_INIT   = 16'h3692;
  localparam logic [15:0] CRC16_POLY   = 16'h8408;
  localparam logic [9:0]  MAX_PAYLOAD  = 10'd1010;
  localparam logic [10:0] FRAME_OVERHEAD = 11'd13;
  localparam logic [7:0]  VERSION_BITS = 8'h04;

  localparam int IN_WIDTH  = 80;
  localparam int OUT_WIDTH = 8;

  // byte positions within the results of one input item
  localparam logic [3:0] POS_SYNC     = 4'd0;
  localparam logic [3:0] POS_LEN_LO   = 4'd1;
  localparam logic [3:0] POS_LEN_HI   = 4'd2;
  localparam logic [3:0] POS_HDR_CRC  = 4'd3;
  localparam logic [3:0] POS_SRC      = 4'd4;
  localparam logic [3:0] POS_DST      = 4'd5;
  localparam logic [3:0] POS_SEQ_LO   = 4'd6;
  localparam logic [3:0] POS_SEQ_HI   = 4'd7;
  localparam logic [3:0] POS_FLAGS    = 4'd8;
  localparam logic [3:0] POS_CMD_SET  = 4'd9;
  localparam logic [3:0] POS_CMD_ID   = 4'd10;
  localparam logic [3:0] POS_DATA     = 4'd11;
  localparam logic [3:0] POS_CRC_LO   = 4'd12;
  localparam logic [3:0] POS_CRC_HI   = 4'd13;

  // reflected crc-8 over one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC8_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // reflected crc-16 over one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC16_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ===== src/crc_framed_packet_encoder.sv =====
// Framed packet encoder: crc-8 protected header, crc-16 trailer.
// Each accepted item is held in the work registers and its bytes are loaded into the
// output register; bytes leave one per cycle while m_axis_tready is high, a rate set
// by the single output byte lane. A payload item yields 1 byte (3 for the last one),
// a start item 12 bytes (14 with a one-byte payload, 13 if empty, 1 if too long).
// Reset (rst, synchronous, active high): idle, no frame open, crc at its seed.
module crc_framed_packet_encoder (
  input  logic        clk,
  input  logic        rst,
  // fields from bit 0: data_byte[7:0], source_addr[15:8], dest_addr[23:16],
  // seq_number[39:24], flag_bits[47:40], cmd_set[55:48], cmd_id[63:56],
  // payload_len[73:64], zero fill[79:74]
  input  logic [crcfpe_pkg::IN_WIDTH-1:0]  s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // fields from bit 0: out_byte[7:0]
  output logic [crcfpe_pkg::OUT_WIDTH-1:0] m_axis_tdata,
  output logic        m_axis_tlast,   // frame_end
  output logic        m_axis_tuser,   // too_long
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  // held input item
  logic        work_valid;
  logic [3:0]  pos;
  logic [7:0]  w_data;
  logic [7:0]  w_src;
  logic [7:0]  w_dst;
  logic [15:0] w_seq;
  logic [7:0]  w_flags;
  logic [7:0]  w_cmd_set;
  logic [7:0]  w_cmd_id;
  logic [9:0]  w_plen;

  // frame state
  logic        in_frame, in_frame_next;
  logic [9:0]  bytes_left, bytes_left_next;
  logic [15:0] crc16, crc16_next;
  logic [7:0]  crc8, crc8_next;
  logic [3:0]  pos_next;

  // sequencer outputs
  logic        out_load;
  logic        step;
  logic        work_done;
  logic [7:0]  emit_byte;
  logic        emit_end;
  logic        emit_err;
  logic [7:0]  hdr_byte;
  logic [10:0] total_len;
  logic [9:0]  remaining;
  logic        in_xfer;

  assign out_load      = !m_axis_tvalid || m_axis_tready;
  assign step          = work_valid && out_load;
  assign s_axis_tready = !work_valid || work_done;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign total_len = {1'b0, w_plen} + crcfpe_pkg::FRAME_OVERHEAD;

  // header byte at the current position
  always_comb begin
    hdr_byte = 8'h00;
    unique case (pos)
      crcfpe_pkg::POS_SYNC:    hdr_byte = crcfpe_pkg::SYNC_BYTE;
      crcfpe_pkg::POS_LEN_LO:  hdr_byte = total_len[7:0];
      crcfpe_pkg::POS_LEN_HI:  hdr_byte = crcfpe_pkg::VERSION_BITS | {6'd0, total_len[9:8]};
      crcfpe_pkg::POS_HDR_CRC: hdr_byte = crc8;
      crcfpe_pkg::POS_SRC:     hdr_byte = w_src;
      crcfpe_pkg::POS_DST:     hdr_byte = w_dst;
      crcfpe_pkg::POS_SEQ_LO:  hdr_byte = w_seq[7:0];
      crcfpe_pkg::POS_SEQ_HI:  hdr_byte = w_seq[15:8];
      crcfpe_pkg::POS_FLAGS:   hdr_byte = w_flags;
      crcfpe_pkg::POS_CMD_SET: hdr_byte = w_cmd_set;
      crcfpe_pkg::POS_CMD_ID:  hdr_byte = w_cmd_id;
      default:                 hdr_byte = 8'h00;
    endcase
  end

  assign remaining = (in_frame ? bytes_left : w_plen) - 10'd1;

  // one byte per step: header, payload byte, then crc trailer, or a single error byte for a too-long request
  always_comb begin
    emit_byte       = 8'h00;
    emit_end        = 1'b0;
    emit_err        = 1'b0;
    work_done       = 1'b0;
    pos_next        = pos;
    crc16_next      = crc16;
    crc8_next       = crc8;
    in_frame_next   = in_frame;
    bytes_left_next = bytes_left;
    if (step) begin
      priority if (!in_frame && pos <= crcfpe_pkg::POS_CMD_ID) begin
        if (pos == crcfpe_pkg::POS_SYNC && w_plen > crcfpe_pkg::MAX_PAYLOAD) begin
          emit_end  = 1'b1;
          emit_err  = 1'b1;
          work_done = 1'b1;
        end else begin
          emit_byte  = hdr_byte;
          crc16_next = crcfpe_pkg::crc16_step(crc16, hdr_byte);
          if (pos == crcfpe_pkg::POS_SYNC) begin
            crc8_next = crcfpe_pkg::crc8_step(crcfpe_pkg::CRC8_INIT, crcfpe_pkg::SYNC_BYTE);
          end else if (pos == crcfpe_pkg::POS_LEN_LO || pos == crcfpe_pkg::POS_LEN_HI) begin
            crc8_next = crcfpe_pkg::crc8_step(crc8, hdr_byte);
          end
          if (pos == crcfpe_pkg::POS_CMD_ID) begin
            pos_next = (w_plen == 10'd0) ? crcfpe_pkg::POS_CRC_LO : crcfpe_pkg::POS_DATA;
          end else begin
            pos_next = pos + 4'd1;
          end
        end
      end else if (pos == crcfpe_pkg::POS_DATA) begin
        emit_byte  = w_data;
        crc16_next = crcfpe_pkg::crc16_step(crc16, w_data);
        if (remaining == 10'd0) begin
          pos_next = crcfpe_pkg::POS_CRC_LO;
        end else begin
          in_frame_next   = 1'b1;
          bytes_left_next = remaining;
          work_done       = 1'b1;
        end
      end else if (pos == crcfpe_pkg::POS_CRC_LO) begin
        emit_byte = crc16[7:0];
        pos_next  = crcfpe_pkg::POS_CRC_HI;
      end else begin
        emit_byte       = crc16[15:8];
        emit_end        = 1'b1;
        in_frame_next   = 1'b0;
        bytes_left_next = 10'd0;
        crc16_next      = crcfpe_pkg::CRC16_INIT;
        work_done       = 1'b1;
      end
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
      pos        <= crcfpe_pkg::POS_SYNC;
      in_frame   <= 1'b0;
      bytes_left <= 10'd0;
      crc16      <= crcfpe_pkg::CRC16_INIT;
      crc8       <= crcfpe_pkg::CRC8_INIT;
      m_axis_tvalid <= 1'b0;
    end else begin
      in_frame   <= in_frame_next;
      bytes_left <= bytes_left_next;
      crc16      <= crc16_next;
      crc8       <= crc8_next;
      if (in_xfer) begin
        work_valid <= 1'b1;
        pos        <= in_frame_next ? crcfpe_pkg::POS_DATA : crcfpe_pkg::POS_SYNC;
      end else begin
        if (work_done) begin
          work_valid <= 1'b0;
        end
        pos <= pos_next;
      end
      if (out_load) begin
        m_axis_tvalid <= step;
      end
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_data    <= s_axis_tdata[7:0];
      w_src     <= s_axis_tdata[15:8];
      w_dst     <= s_axis_tdata[23:16];
      w_seq     <= s_axis_tdata[39:24];
      w_flags   <= s_axis_tdata[47:40];
      w_cmd_set <= s_axis_tdata[55:48];
      w_cmd_id  <= s_axis_tdata[63:56];
      w_plen    <= s_axis_tdata[73:64];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= emit_byte;
      m_axis_tlast <= emit_end;
      m_axis_tuser <= emit_err;
    end
  end

  // checks
  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result without frame end");

  a_left_only_in_frame: assert property (@(posedge clk) disable iff (rst)
    !in_frame |-> bytes_left == 10'd0)
    else $error("payload count set outside a frame");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    work_valid |-> pos <= crcfpe_pkg::POS_CRC_HI)
    else $error("sequence position out of range");

  a_crc_seed_at_start: assert property (@(posedge clk) disable iff (rst)
    !in_frame && work_valid && pos == crcfpe_pkg::POS_SYNC |-> crc16 == crcfpe_pkg::CRC16_INIT)
    else $error("crc not at seed at frame start");

  a_done_frees_input: assert property (@(posedge clk) disable iff (rst)
    work_done |-> s_axis_tready)
    else $error("finished item does not free the input");

endmodule

// ===== bench/tb_crc_framed_packet_encoder.sv =====
// tb_crc_framed_packet_encoder: self-checking bench for the framed packet encoder
// drives start and payload transfers, predicts every output byte, compares in order
// depends on crcfpe_pkg and crc_framed_packet_encoder
`timescale 1ns / 1ps

module tb_crc_framed_packet_encoder;

  // random frames run until this many transfers, then a long and a short frame follow
  localparam int RANDOM_ITEMS   = 230;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 20;
  localparam int MAX_REPORTS    = 40;

  // one input transfer, packed so data_byte lands in the lowest bits
  typedef struct packed {
    logic [9:0]  payload_len;
    logic [7:0]  cmd_id;
    logic [7:0]  cmd_set;
    logic [7:0]  flag_bits;
    logic [15:0] seq_number;
    logic [7:0]  dest_addr;
    logic [7:0]  source_addr;
    logic [7:0]  data_byte;
  } frame_item_t;

  // one output transfer
  typedef struct packed {
    logic       too_long;
    logic       frame_end;
    logic [7:0] out_byte;
  } enc_byte_t;

  typedef struct {
    frame_item_t item;
    bit          fixed;
  } stim_row_t;

  localparam enc_byte_t OVERSIZE_RESULT = '{too_long: 1'b1, frame_end: 1'b1, out_byte: 8'h00};

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic [crcfpe_pkg::IN_WIDTH-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [crcfpe_pkg::OUT_WIDTH-1:0] m_axis_tdata;
  logic                             m_axis_tlast;
  logic                             m_axis_tuser;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;

  // predictor state
  logic        frame_open = 1'b0;
  logic [9:0]  payload_remaining = '0;
  logic [15:0] frame_crc = crcfpe_pkg::CRC16_INIT;
  enc_byte_t   frame_bytes_due[$];

  // bookkeeping
  int mismatches = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_closed = 0;
  int oversize_seen = 0;
  int idle_cycles = 0;
  bit src_burst = 1'b0;
  int sink_phase = 0;
  int sink_hold = 0;
  bit sink_free = 1'b0;

  stim_row_t directed_rows[$];

  crc_framed_packet_encoder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk = ~clk;

  // reflected crc-8, one input bit at a time
  function automatic logic [7:0] hdr_crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) acc = acc ^ crcfpe_pkg::CRC8_POLY;
    end
    return acc;
  endfunction

  // reflected crc-16, one input bit at a time
  function automatic logic [15:0] trail_crc16_byte(input logic [15:0] acc, input logic [7:0] b);
    logic fb;
    for (int k = 0; k < 8; k++) begin
      fb  = acc[0] ^ b[k];
      acc = acc >> 1;
      if (fb) acc = acc ^ crcfpe_pkg::CRC16_POLY;
    end
    return acc;
  endfunction

  // append one expected output byte at the tail of the queue
  task automatic queue_due_byte(input enc_byte_t e);
    frame_bytes_due.insert(frame_bytes_due.size(), e);
  endtask

  task automatic expect_frame_byte(input logic [7:0] b);
    frame_crc = trail_crc16_byte(frame_crc, b);
    queue_due_byte('{too_long: 1'b0, frame_end: 1'b0, out_byte: b});
  endtask

  task automatic expect_trailer();
    queue_due_byte('{too_long: 1'b0, frame_end: 1'b0, out_byte: frame_crc[7:0]});
    queue_due_byte('{too_long: 1'b0, frame_end: 1'b1, out_byte: frame_crc[15:8]});
    frame_open        = 1'b0;
    payload_remaining = '0;
    frame_crc         = crcfpe_pkg::CRC16_INIT;
  endtask

  // expected output bytes for one accepted input transfer
  task automatic encode_item(input frame_item_t it);
    logic [10:0] total_len;
    logic [7:0]  hdr[11];
    // payload byte inside an open frame, other fields ignored
    if (frame_open) begin
      expect_frame_byte(it.data_byte);
      payload_remaining = payload_remaining - 10'd1;
      if (payload_remaining == 10'd0) expect_trailer();
      return;
    end
    // oversize request: single error byte, stay idle
    if (it.payload_len > crcfpe_pkg::MAX_PAYLOAD) begin
      queue_due_byte(OVERSIZE_RESULT);
      return;
    end
    total_len = {1'b0, it.payload_len} + crcfpe_pkg::FRAME_OVERHEAD;
    hdr[0]  = crcfpe_pkg::SYNC_BYTE;
    hdr[1]  = total_len[7:0];
    hdr[2]  = crcfpe_pkg::VERSION_BITS | {6'b0, total_len[9:8]};
    hdr[3]  = hdr_crc8_byte(hdr_crc8_byte(hdr_crc8_byte(crcfpe_pkg::CRC8_INIT, hdr[0]),
                                          hdr[1]), hdr[2]);
    hdr[4]  = it.source_addr;
    hdr[5]  = it.dest_addr;
    hdr[6]  = it.seq_number[7:0];
    hdr[7]  = it.seq_number[15:8];
    hdr[8]  = it.flag_bits;
    hdr[9]  = it.cmd_set;
    hdr[10] = it.cmd_id;
    frame_crc = crcfpe_pkg::CRC16_INIT;
    for (int i = 0; i < 11; i++) expect_frame_byte(hdr[i]);
    // empty payload closes right after the header
    if (it.payload_len == 10'd0) begin
      expect_trailer();
      return;
    end
    expect_frame_byte(it.data_byte);
    payload_remaining = it.payload_len - 10'd1;
    if (payload_remaining == 10'd0) expect_trailer();
    else frame_open = 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (src_burst || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic frame_item_t rand_item();
    frame_item_t it;
    it = {10'($urandom), 32'($urandom), 32'($urandom)};
    return it;
  endfunction

  // one transfer on the slave side; valid stays high across back-to-back transfers
  task automatic send_item(input frame_item_t it, input bit fixed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), 32'($urandom), 32'($urandom)};
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {6'b0, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    if (fixed) queue_due_byte(OVERSIZE_RESULT);
    else encode_item(it);
    items_sent++;
  endtask

  // start transfer plus its payload transfers, random content throughout
  task automatic send_frame(input logic [9:0] plen);
    frame_item_t it;
    src_burst = ($urandom_range(0, 4) == 0);
    it = rand_item();
    it.payload_len = plen;
    send_item(it, 1'b0);
    if (plen > crcfpe_pkg::MAX_PAYLOAD) return;
    for (int i = 1; i < plen; i++) send_item(rand_item(), 1'b0);
  endtask

  task automatic add_row(input logic [7:0] data, input logic [7:0] src, input logic [7:0] dst,
                         input logic [15:0] seq, input logic [7:0] flags,
                         input logic [7:0] cset, input logic [7:0] cid,
                         input logic [9:0] plen, input bit fixed);
    stim_row_t row;
    row.item  = '{payload_len: plen, cmd_id: cid, cmd_set: cset, flag_bits: flags,
                  seq_number: seq, dest_addr: dst, source_addr: src, data_byte: data};
    row.fixed = fixed;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // master side ready: stretches of free flow, and stretches of short and long stalls
  always @(posedge clk) begin
    if (sink_phase == 0) begin
      sink_phase = $urandom_range(50, 300);
      sink_free  = ($urandom_range(0, 3) == 0);
    end
    sink_phase--;
    if (sink_hold > 0) begin
      sink_hold--;
      m_axis_tready <= 1'b0;
    end else if (!sink_free && $urandom_range(0, 99) < 25) begin
      sink_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // output checker and watchdog
  always @(posedge clk) begin
    enc_byte_t got;
    enc_byte_t want;
    if (!rst) begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
        got = '{too_long: m_axis_tuser, frame_end: m_axis_tlast, out_byte: m_axis_tdata};
        bytes_checked++;
        if (frame_bytes_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected byte: got out_byte %02h frame_end %0b too_long %0b",
                     $realtime, got.out_byte, got.frame_end, got.too_long);
        end else begin
          want = frame_bytes_due.pop_front();
          if (want.too_long) oversize_seen++;
          else if (want.frame_end) frames_closed++;
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display(
                "%0t: mismatch: expected %02h end %0b err %0b, got %02h end %0b err %0b",
                $realtime, want.out_byte, want.frame_end, want.too_long,
                got.out_byte, got.frame_end, got.too_long);
          end
        end
      end
      if ((m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) ||
          (s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d bytes still due",
                 $realtime, idle_cycles, frame_bytes_due.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: length limits, empty frames, single-byte frames, ignored fields
    add_row(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd1011, 1'b1);
    add_row(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023, 1'b1);
    add_row(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd0, 1'b0);
    add_row(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd0, 1'b0);
    add_row(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd1, 1'b0);
    add_row(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd1, 1'b0);
    // four-byte frame; payload transfers carry length fields (mostly oversize) that must be ignored
    add_row(8'hA5, 8'h12, 8'h34, 16'h8001, 8'h80, 8'h01, 8'h7F, 10'd4, 1'b0);
    add_row(8'h00, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd1023, 1'b0);
    add_row(8'hFF, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd0, 1'b0);
    add_row(8'h5A, 8'hAA, 8'h55, 16'h5AA5, 8'h0F, 8'hF0, 8'h3C, 10'd1011, 1'b0);
    add_row(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd1012, 1'b1);
    add_row(8'h3C, 8'h01, 8'h02, 16'h00FF, 8'h10, 8'h20, 8'h30, 10'd2, 1'b0);
    add_row(8'hC3, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 10'd1010, 1'b0);
    add_row(8'h77, 8'hFE, 8'h7F, 16'hFF00, 8'h01, 8'h80, 8'hFE, 10'd0, 1'b0);
    add_row(8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 10'd1020, 1'b1);
    foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].fixed);

    // random frames, mostly short, some empty, some oversize requests
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       send_frame(10'($urandom_range(1011, 1023)));
        1:       send_frame(10'd0);
        2:       send_frame(10'($urandom_range(25, 80)));
        default: send_frame(10'($urandom_range(1, 24)));
      endcase
    end

    // a long frame whose total length wraps the length low byte, then a short one
    send_frame(10'd243);
    send_frame(10'd1);

    s_axis_tvalid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transfers: %0d frames closed, %0d oversize requests",
             items_sent, frames_closed, oversize_seen);
    $display("%0d output bytes compared, %0d mismatches", bytes_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
